FILE: hw/rtl/filtered_byte_histogram_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef FILTERED_BYTE_HISTOGRAM_TOP_ASSERT_SVH
`define FILTERED_BYTE_HISTOGRAM_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define FBH_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define FBH_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/fbh_pkg.sv
package fbh_pkg;

    localparam int BIN_COUNT_DEF   = 256;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int OUT_W     = 32;
    localparam int PCT_W     = 23;
    localparam int PCT_BIT_W = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int MASK_W    = 256;

    localparam logic [PCT_W-1:0] PCT_SCALE = 23'd6553600;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 88;
    localparam int M_BIN_LO  = 0;
    localparam int M_TOT_LO  = 32;
    localparam int M_PCT_LO  = 64;

    localparam logic [1:0] FILTER_INCLUDE = 2'd1;
    localparam logic [1:0] FILTER_EXCLUDE = 2'd2;

    localparam logic MODE_READ = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FILTER_MODE = 3'd0,
        REG_TOTAL_ALL   = 3'd1,
        REG_SET_MASK_0  = 3'd2,
        REG_SET_MASK_1  = 3'd3,
        REG_SET_MASK_2  = 3'd4,
        REG_SET_MASK_3  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_DELIVER
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SHIFT,
        DIV_ADD,
        DIV_DONE
    } div_state_t;

endpackage

FILE: hw/rtl/fbh_divider.sv
module fbh_divider #(
    parameter int COUNT_WIDTH = fbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [COUNT_WIDTH-1:0]   bin,
    input  logic [COUNT_WIDTH-1:0]   total,
    output logic                     done,
    output logic [fbh_pkg::PCT_W-1:0] quotient
);

    // Computes floor(bin * 6553600 / total) capped at 6553600, 0 for a zero
    // total, one scale bit per pass: a shift step and, where the scale bit is
    // set, an add step, each ending in one compare and subtract against the total.

    fbh_pkg::div_state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0]        bin_reg, bin_next;
    logic [COUNT_WIDTH-1:0]        total_reg, total_next;
    logic [COUNT_WIDTH-1:0]        rem_reg, rem_next;
    logic [fbh_pkg::PCT_W-1:0]     q_reg, q_next;
    logic [fbh_pkg::PCT_BIT_W-1:0] bit_reg, bit_next;

    logic [COUNT_WIDTH:0] shifted;
    logic [COUNT_WIDTH:0] summed;
    logic [COUNT_WIDTH:0] total_ext;
    logic                 shift_ge;
    logic                 add_ge;
    logic                 trivial;
    logic                 last_bit;

    assign total_ext = {1'b0, total_reg};
    assign shifted   = {rem_reg, 1'b0};
    assign summed    = {1'b0, rem_reg} + {1'b0, bin_reg};
    assign shift_ge  = shifted >= total_ext;
    assign add_ge    = summed >= total_ext;
    assign trivial   = (total == '0) || (bin == '0) || (bin >= total);
    assign last_bit  = bit_reg == '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fbh_pkg::DIV_IDLE: begin
                if (start) begin
                    state_next = trivial ? fbh_pkg::DIV_DONE : fbh_pkg::DIV_SHIFT;
                end
            end
            fbh_pkg::DIV_SHIFT: begin
                if (fbh_pkg::PCT_SCALE[bit_reg]) begin
                    state_next = fbh_pkg::DIV_ADD;
                end else if (last_bit) begin
                    state_next = fbh_pkg::DIV_DONE;
                end
            end
            fbh_pkg::DIV_ADD: begin
                state_next = last_bit ? fbh_pkg::DIV_DONE : fbh_pkg::DIV_SHIFT;
            end
            fbh_pkg::DIV_DONE: begin
                state_next = fbh_pkg::DIV_IDLE;
            end
            default: begin
                state_next = fbh_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        bin_next   = bin_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        done       = 1'b0;
        unique case (state_reg)
            fbh_pkg::DIV_IDLE: begin
                if (start) begin
                    bin_next   = bin;
                    total_next = total;
                    rem_next   = '0;
                    bit_next   = fbh_pkg::PCT_BIT_W'(fbh_pkg::PCT_W - 1);
                    if ((total != '0) && (bin != '0) && (bin >= total)) begin
                        q_next = fbh_pkg::PCT_SCALE;
                    end else begin
                        q_next = '0;
                    end
                end
            end
            fbh_pkg::DIV_SHIFT: begin
                rem_next = shift_ge ? COUNT_WIDTH'(shifted - total_ext)
                                    : COUNT_WIDTH'(shifted);
                q_next   = {q_reg[fbh_pkg::PCT_W-2:0], shift_ge};
                if (!fbh_pkg::PCT_SCALE[bit_reg] && !last_bit) begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            fbh_pkg::DIV_ADD: begin
                rem_next = add_ge ? COUNT_WIDTH'(summed - total_ext)
                                  : COUNT_WIDTH'(summed);
                q_next   = q_reg + fbh_pkg::PCT_W'(add_ge);
                if (!last_bit) begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            fbh_pkg::DIV_DONE: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbh_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg   <= bin_next;
        total_reg <= total_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
    end

    assign quotient = q_reg;

endmodule

FILE: hw/rtl/filtered_byte_histogram_top.sv
// Channel   Direction  Ports                        Contents
// s_        in         s_tvalid s_tready s_tdata    count or read request word
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata    bin read result word
//                      m_tuser
// cfg_      in         cfg_wr_en cfg_addr cfg_wdata register writes
//
// A count word is a bin read from the bin memory, then the write back.
// A read word goes through lookup, 23 shift steps and 3 add steps of the divider,
// finish and delivery; trivial shares skip the loop.
// Reset is synchronous and active low; per-bin valid flags clear all bins at once.
// A stalled result sits in the output register; count words are still taken, and
// one more read word is held at its last step until the output register frees up.
module filtered_byte_histogram_top #(
    parameter int BIN_COUNT   = fbh_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = fbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte [7:0], bin_index [15:8]
    input  logic [fbh_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bin_count [31:0], total_count [63:32], percent_q16 [86:64], zero [87]
    output logic [fbh_pkg::M_TDATA_W-1:0]     m_tdata,
    // bin_nonzero [0]
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [fbh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fbh_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [fbh_pkg::BYTE_W:0] BIN_LIMIT = (fbh_pkg::BYTE_W + 1)'(BIN_COUNT);

    fbh_pkg::top_state_t state_reg, state_next;

    logic [1:0]                  filter_mode_reg;
    logic                        total_all_reg;
    logic [fbh_pkg::MASK_W-1:0]  set_mask_reg;

    logic [COUNT_WIDTH-1:0] bins_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]   bin_valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   in_range_reg;
    logic                   bin_inc_reg;
    logic                   tot_inc_reg;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic                        out_valid_reg, out_valid_next;
    logic [fbh_pkg::OUT_W-1:0]   out_bin_reg, out_bin_next;
    logic [fbh_pkg::OUT_W-1:0]   out_total_reg, out_total_next;
    logic [fbh_pkg::PCT_W-1:0]   out_pct_reg, out_pct_next;
    logic                        out_nz_reg, out_nz_next;

    logic [fbh_pkg::BYTE_W-1:0] s_data_byte;
    logic [fbh_pkg::BYTE_W-1:0] s_bin_index;
    logic [fbh_pkg::BYTE_W-1:0] s_byte_sel;
    logic [IDX_W-1:0]           s_addr;
    logic                       s_accept;
    logic                       s_in_range;
    logic                       member;
    logic                       selected;
    logic                       filtered;

    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [COUNT_WIDTH-1:0] inc_total;
    logic                   mem_we;
    logic                   div_start;
    logic                   div_done;
    logic [fbh_pkg::PCT_W-1:0] div_q;
    logic                   out_free;

    assign s_data_byte = s_tdata[fbh_pkg::BYTE_W-1:0];
    assign s_bin_index = s_tdata[2*fbh_pkg::BYTE_W-1:fbh_pkg::BYTE_W];
    assign s_byte_sel  = (s_tuser == fbh_pkg::MODE_READ) ? s_bin_index : s_data_byte;
    assign s_addr      = IDX_W'(s_byte_sel);
    assign s_in_range  = {1'b0, s_byte_sel} < BIN_LIMIT;
    assign s_accept    = s_tvalid && s_tready;

    assign member   = set_mask_reg[s_data_byte];
    assign filtered = (filter_mode_reg == fbh_pkg::FILTER_INCLUDE)
                   || (filter_mode_reg == fbh_pkg::FILTER_EXCLUDE);
    always_comb begin
        case (filter_mode_reg)
            fbh_pkg::FILTER_INCLUDE: selected = member;
            fbh_pkg::FILTER_EXCLUDE: selected = !member;
            default:                 selected = 1'b1;
        endcase
    end

    assign cur_count = (in_range_reg && rd_valid_reg) ? rd_data_reg : '0;
    assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
    assign inc_total = (&total_reg) ? total_reg : total_reg + 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fbh_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == fbh_pkg::MODE_READ) ? fbh_pkg::ST_LOOKUP
                                                                 : fbh_pkg::ST_UPDATE;
                end
            end
            fbh_pkg::ST_UPDATE: begin
                state_next = fbh_pkg::ST_IDLE;
            end
            fbh_pkg::ST_LOOKUP: begin
                state_next = fbh_pkg::ST_DIVIDE;
            end
            fbh_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = fbh_pkg::ST_DELIVER;
                end
            end
            fbh_pkg::ST_DELIVER: begin
                if (out_free) begin
                    state_next = fbh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_bin_next   = out_bin_reg;
        out_total_next = out_total_reg;
        out_pct_next   = out_pct_reg;
        out_nz_next    = out_nz_reg;
        unique case (state_reg)
            fbh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            fbh_pkg::ST_UPDATE: begin
                mem_we = bin_inc_reg;
                if (tot_inc_reg) begin
                    total_next = inc_total;
                end
            end
            fbh_pkg::ST_LOOKUP: begin
                div_start = 1'b1;
            end
            fbh_pkg::ST_DIVIDE: begin
                s_tready = 1'b0;
            end
            fbh_pkg::ST_DELIVER: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_bin_next   = fbh_pkg::OUT_W'(cur_count);
                    out_total_next = fbh_pkg::OUT_W'(total_reg);
                    out_pct_next   = div_q;
                    out_nz_next    = cur_count != '0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= bins_mem[s_addr];
        end
        if (mem_we) begin
            bins_mem[addr_reg] <= inc_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbh_pkg::ST_IDLE;
            filter_mode_reg <= '0;
            total_all_reg   <= 1'b0;
            set_mask_reg    <= '0;
            bin_valid_reg   <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (mem_we) begin
                bin_valid_reg[addr_reg] <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    fbh_pkg::REG_FILTER_MODE: filter_mode_reg <= cfg_wdata[1:0];
                    fbh_pkg::REG_TOTAL_ALL:   total_all_reg   <= cfg_wdata[0];
                    fbh_pkg::REG_SET_MASK_0:  set_mask_reg[63:0]    <= cfg_wdata;
                    fbh_pkg::REG_SET_MASK_1:  set_mask_reg[127:64]  <= cfg_wdata;
                    fbh_pkg::REG_SET_MASK_2:  set_mask_reg[191:128] <= cfg_wdata;
                    fbh_pkg::REG_SET_MASK_3:  set_mask_reg[255:192] <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        if (s_accept) begin
            rd_valid_reg <= bin_valid_reg[s_addr];
            addr_reg     <= s_addr;
            in_range_reg <= s_in_range;
            bin_inc_reg  <= s_in_range && selected;
            tot_inc_reg  <= s_in_range && (selected || (total_all_reg && filtered));
        end
        out_bin_reg   <= out_bin_next;
        out_total_reg <= out_total_next;
        out_pct_reg   <= out_pct_next;
        out_nz_reg    <= out_nz_next;
    end

    fbh_divider #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .bin      (cur_count),
        .total    (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pct_reg, out_total_reg, out_bin_reg};
    assign m_tuser  = out_nz_reg;

endmodule

FILE: hw/rtl/fbh_checker.sv
`include "filtered_byte_histogram_top_assert.svh"

module fbh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fbh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    logic [fbh_pkg::OUT_W-1:0] bin_field;
    logic [fbh_pkg::PCT_W-1:0] pct_field;

    assign bin_field = m_tdata[fbh_pkg::M_TOT_LO-1:fbh_pkg::M_BIN_LO];
    assign pct_field = m_tdata[fbh_pkg::M_PCT_LO+fbh_pkg::PCT_W-1:fbh_pkg::M_PCT_LO];

    `FBH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FBH_ASSERT_NEXT(a_busy_after_word, s_tvalid && s_tready, !s_tready)
    `FBH_ASSERT_NOW(a_nonzero_flag, m_tvalid && (bin_field != '0), m_tuser)
    `FBH_ASSERT_NOW(a_pct_range, m_tvalid, (pct_field <= fbh_pkg::PCT_SCALE) && (m_tuser || (pct_field == '0)))

endmodule

bind filtered_byte_histogram_top fbh_checker u_fbh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
